// ===== design/bilinear_grid_upscaler_assert.svh =====
// ----------------------------------------------------------------------------
// bilinear_grid_upscaler_assert: assertion macros
// Same-cycle and next-cycle implication checks on one clock with a disable.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_GRID_UPSCALER_ASSERT_SVH
`define BILINEAR_GRID_UPSCALER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BGU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check cons in the cycle after ante.
`define BGU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/bgu_pkg.sv =====
// ----------------------------------------------------------------------------
// bgu_pkg: shared types and constants
// Field widths, blend widths, register codes and the divide-by-255 constant.
// ----------------------------------------------------------------------------
package bgu_pkg;

   localparam int MAX_NODES_PER_SIDE = 16;
   localparam int MAX_SIZE_LOG2      = 12;
   localparam int WEIGHT_BITS        = 8;
   localparam int STORE_DEPTH        = MAX_NODES_PER_SIDE * MAX_NODES_PER_SIDE;

   localparam int CHAN_W   = 8;
   localparam int COORD_W  = 12;
   localparam int CELLS_W  = 4;
   localparam int SHIFT_W  = 4;
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int P_W      = COORD_W + CELLS_W;
   localparam int STRIDE_W = CELLS_W + 1;
   localparam int ROW_W    = CELLS_W + STRIDE_W;
   localparam int HB_W     = CHAN_W + WEIGHT_BITS;
   localparam int VB_W     = CHAN_W + 2 * WEIGHT_BITS;
   localparam int OUT_W    = 16;
   localparam int Q_W      = OUT_W + 1;
   localparam int NUM_CH   = 3;
   localparam int NUM_CORNERS = 4;

   // floor(v / 255) == (v * RECIP_255) >> DIV_SHIFT for every v below 2^24
   localparam int RECIP_W   = 25;
   localparam int DIV_SHIFT = 32;
   localparam int DIVP_W    = VB_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

   typedef logic [CHAN_W-1:0]      chan_type;
   typedef logic [COORD_W-1:0]     coord_type;
   typedef logic [CELLS_W-1:0]     cells_type;
   typedef logic [SHIFT_W-1:0]     shift_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [P_W-1:0]         prod_type;
   typedef logic [WEIGHT_BITS-1:0] frac_type;
   typedef logic [HB_W-1:0]        hblend_type;
   typedef logic [VB_W-1:0]        vblend_type;
   typedef logic [OUT_W-1:0]       out_type;
   typedef logic [1:0]             csr_index_type;
   typedef logic [3:0]             csr_data_type;
   typedef logic [1:0]             ch_sel_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } node_type;

   typedef struct packed {
      cells_type cell_num;
      frac_type  frac;
   } split_type;

   localparam logic MODE_NODE  = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   localparam csr_index_type CSR_CELLS_X   = 2'd0;
   localparam csr_index_type CSR_CELLS_Y   = 2'd1;
   localparam csr_index_type CSR_SIZE_LOG2 = 2'd2;

   localparam cells_type RESET_CELLS = 4'd9;
   localparam shift_type RESET_SHIFT = 4'd9;
   localparam cells_type MAX_CELLS   = cells_type'(MAX_NODES_PER_SIDE - 1);
   localparam shift_type MAX_SHIFT   = shift_type'(MAX_SIZE_LOG2);

   localparam ch_sel_type CH_RED   = 2'd0;
   localparam ch_sel_type CH_GREEN = 2'd1;
   localparam ch_sel_type CH_BLUE  = 2'd2;

   localparam int CORNER_00 = 0;
   localparam int CORNER_10 = 1;
   localparam int CORNER_01 = 2;
   localparam int CORNER_11 = 3;

endpackage

// ===== design/bgu_req_if.sv =====
// ----------------------------------------------------------------------------
// bgu_req_if: request channel
// Node write or pixel request word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bgu_req_if;
   import bgu_pkg::*;

   logic      valid;
   logic      ready;
   logic      mode;
   addr_type  node_index;
   chan_type  node_red;
   chan_type  node_green;
   chan_type  node_blue;
   coord_type pixel_x;
   coord_type pixel_y;

   modport source (
      output valid, mode, node_index, node_red, node_green, node_blue, pixel_x, pixel_y,
      input  ready
   );

   modport sink (
      input  valid, mode, node_index, node_red, node_green, node_blue, pixel_x, pixel_y,
      output ready
   );
endinterface

// ===== design/bgu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bgu_rsp_if: response channel
// Interpolated RGB pixel word in 0.16 form with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bgu_rsp_if;
   import bgu_pkg::*;

   logic    valid;
   logic    ready;
   out_type out_red;
   out_type out_green;
   out_type out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );
endinterface

// ===== design/bgu_csr_if.sv =====
// ----------------------------------------------------------------------------
// bgu_csr_if: configuration write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bgu_csr_if;
   import bgu_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== design/bgu_split.sv =====
// ----------------------------------------------------------------------------
// bgu_split: coordinate split
// Turn a scaled coordinate into a cell number and a weight fraction.
// ----------------------------------------------------------------------------
module bgu_split (
   input  bgu_pkg::prod_type  prod,
   input  bgu_pkg::shift_type shift,
   output bgu_pkg::split_type part
);
   import bgu_pkg::*;

   prod_type                      mask;
   prod_type                      rem;
   prod_type                      cell_full;
   logic [P_W+WEIGHT_BITS-1:0]    frac_wide;

   always_comb begin
      mask          = ~({P_W{1'b1}} << shift);
      rem           = prod & mask;
      cell_full     = prod >> shift;
      frac_wide     = {rem, {WEIGHT_BITS{1'b0}}} >> shift;
      part.cell_num = cell_full[CELLS_W-1:0];
      part.frac     = frac_wide[WEIGHT_BITS-1:0];
   end
endmodule

// ===== design/bgu_ram.sv =====
// ----------------------------------------------------------------------------
// bgu_ram: generic single-port RAM
// One access per cycle when enabled, write or registered read.
// ----------------------------------------------------------------------------
module bgu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/bilinear_grid_upscaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_grid_upscaler: bilinear RGB grid upscaler
// Pixel requests pass six registered stages in order; node writes end at stage 3.
// Throughput: 1 word per cycle while rsp_if.ready holds, set by 4 store copies.
// Reset clears all valid bits and loads cells_x, cells_y and size_log2 with 9.
// The grid store is not cleared; each node must be written before it is read.
// ----------------------------------------------------------------------------
module bilinear_grid_upscaler (
   input  logic      clock,
   input  logic      reset,
   bgu_req_if.sink   req_if,
   bgu_rsp_if.source rsp_if,
   bgu_csr_if.sink   csr_if
);
   import bgu_pkg::*;

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   cells_type cells_x_ff;
   cells_type cells_y_ff;
   shift_type size_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff   <= RESET_CELLS;
         cells_y_ff   <= RESET_CELLS;
         size_log2_ff <= RESET_SHIFT;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_CELLS_X:   cells_x_ff   <= cells_type'(csr_if.data);
            CSR_CELLS_Y:   cells_y_ff   <= cells_type'(csr_if.data);
            CSR_SIZE_LOG2: size_log2_ff <= shift_type'(csr_if.data);
            default: ;
         endcase
      end
   end

   // Always ready; config words must arrive only in an empty pipeline, unchecked.
   assign csr_if.ready = 1'b1;

   // Zero cells act as one cell; clamp cells to what the store holds.
   function automatic cells_type eff_cells(input cells_type c);
      cells_type r;
      r = c;
      if (c == '0) begin
         r = cells_type'(1);
      end else if (c > MAX_CELLS) begin
         r = MAX_CELLS;
      end
      return r;
   endfunction

   cells_type cx_eff;
   cells_type cy_eff;
   shift_type s_eff;

   assign cx_eff = eff_cells(cells_x_ff);
   assign cy_eff = eff_cells(cells_y_ff);
   assign s_eff  = (size_log2_ff > MAX_SHIFT) ? MAX_SHIFT : size_log2_ff;

   // -------------------------------------------------------------------------
   // Elastic stall chain: a stage loads when it is empty or its word moves on.
   // -------------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   assign rdy6 = !v6_ff || rsp_if.ready;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_if.ready = rdy1;

   logic mode2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_if.valid;
         if (rdy2) v2_ff <= v1_ff;
         // Drop node writes here: they finish in the store and give no word.
         if (rdy3) v3_ff <= v2_ff && (mode2_ff == MODE_PIXEL);
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: mask the coordinates to the image size and scale by cell count.
   // -------------------------------------------------------------------------
   coord_type coord_mask;
   coord_type px_masked;
   coord_type py_masked;
   prod_type  px1_in, py1_in;

   logic      mode1_ff;
   addr_type  idx1_ff;
   node_type  node1_ff;
   prod_type  px1_ff, py1_ff;

   always_comb begin
      coord_mask = ~({COORD_W{1'b1}} << s_eff);
      px_masked  = req_if.pixel_x & coord_mask;
      py_masked  = req_if.pixel_y & coord_mask;
      px1_in     = prod_type'(px_masked) * prod_type'(cx_eff);
      py1_in     = prod_type'(py_masked) * prod_type'(cy_eff);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mode1_ff       <= req_if.mode;
         idx1_ff        <= req_if.node_index;
         node1_ff.red   <= req_if.node_red;
         node1_ff.green <= req_if.node_green;
         node1_ff.blue  <= req_if.node_blue;
         px1_ff         <= px1_in;
         py1_ff         <= py1_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: split each scaled coordinate into a cell and an 8-bit weight.
   // -------------------------------------------------------------------------
   split_type sx2_in, sy2_in;
   split_type sx2_ff, sy2_ff;
   addr_type  idx2_ff;
   node_type  node2_ff;

   bgu_split u_split_x (
      .prod  (px1_ff),
      .shift (s_eff),
      .part  (sx2_in)
   );

   bgu_split u_split_y (
      .prod  (py1_ff),
      .shift (s_eff),
      .part  (sy2_in)
   );

   always_ff @(posedge clock) begin
      if (rdy2) begin
         mode2_ff <= mode1_ff;
         idx2_ff  <= idx1_ff;
         node2_ff <= node1_ff;
         sx2_ff   <= sx2_in;
         sy2_ff   <= sy2_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: form the four corner addresses and access the store.
   // Each corner reads its own copy; a node write goes to all four copies,
   // in the same stage as the reads, so request order is kept.
   // -------------------------------------------------------------------------
   logic [STRIDE_W-1:0] stride;
   logic [ROW_W-1:0]    row00, row10, row01, row11;
   addr_type            rd_addr [NUM_CORNERS];
   addr_type            ram_addr [NUM_CORNERS];
   node_type            corner [NUM_CORNERS];
   logic                ram_en;
   logic                ram_we;

   always_comb begin
      stride = STRIDE_W'(cx_eff) + STRIDE_W'(1);
      row00  = ROW_W'(sy2_ff.cell_num) * ROW_W'(stride) + ROW_W'(sx2_ff.cell_num);
      row10  = row00 + ROW_W'(1);
      row01  = row00 + ROW_W'(stride);
      row11  = row01 + ROW_W'(1);
      rd_addr[CORNER_00] = row00[ADDR_W-1:0];
      rd_addr[CORNER_10] = row10[ADDR_W-1:0];
      rd_addr[CORNER_01] = row01[ADDR_W-1:0];
      rd_addr[CORNER_11] = row11[ADDR_W-1:0];
   end

   assign ram_en = rdy3 && v2_ff;
   assign ram_we = (mode2_ff == MODE_NODE);

   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_store
      assign ram_addr[k] = ram_we ? idx2_ff : rd_addr[k];

      bgu_ram #(
         .WIDTH ($bits(node_type)),
         .DEPTH (STORE_DEPTH)
      ) u_ram (
         .clock (clock),
         .en    (ram_en),
         .we    (ram_we),
         .addr  (ram_addr[k]),
         .wdata (node2_ff),
         .rdata (corner[k])
      );
   end

   frac_type fx3_ff, fy3_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         fx3_ff <= sx2_ff.frac;
         fy3_ff <= sy2_ff.frac;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 4: horizontal blend of the top and bottom corner pairs.
   // -------------------------------------------------------------------------
   function automatic chan_type chan_of(input node_type n, input ch_sel_type ch);
      chan_type c;
      case (ch)
         CH_RED:   c = n.red;
         CH_GREEN: c = n.green;
         default:  c = n.blue;
      endcase
      return c;
   endfunction

   function automatic hblend_type lerp_h(input chan_type c0, input chan_type c1,
                                         input frac_type f);
      logic [WEIGHT_BITS:0] wf;
      logic [HB_W:0]        sum;
      wf  = {1'b1, {WEIGHT_BITS{1'b0}}} - {1'b0, f};
      sum = (HB_W+1)'(c0) * (HB_W+1)'(wf) + (HB_W+1)'(c1) * (HB_W+1)'(f);
      return sum[HB_W-1:0];
   endfunction

   hblend_type ha4_in [NUM_CH];
   hblend_type hb4_in [NUM_CH];
   hblend_type ha4_ff [NUM_CH];
   hblend_type hb4_ff [NUM_CH];
   frac_type   fy4_ff;

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         ha4_in[ch] = lerp_h(chan_of(corner[CORNER_00], ch_sel_type'(ch)),
                             chan_of(corner[CORNER_10], ch_sel_type'(ch)), fx3_ff);
         hb4_in[ch] = lerp_h(chan_of(corner[CORNER_01], ch_sel_type'(ch)),
                             chan_of(corner[CORNER_11], ch_sel_type'(ch)), fx3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         ha4_ff <= ha4_in;
         hb4_ff <= hb4_in;
         fy4_ff <= fy3_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 5: vertical blend of the two row results.
   // -------------------------------------------------------------------------
   function automatic vblend_type lerp_v(input hblend_type a, input hblend_type b,
                                         input frac_type f);
      logic [WEIGHT_BITS:0] wf;
      logic [VB_W:0]        sum;
      wf  = {1'b1, {WEIGHT_BITS{1'b0}}} - {1'b0, f};
      sum = (VB_W+1)'(a) * (VB_W+1)'(wf) + (VB_W+1)'(b) * (VB_W+1)'(f);
      return sum[VB_W-1:0];
   endfunction

   vblend_type vb5_in [NUM_CH];
   vblend_type vb5_ff [NUM_CH];

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         vb5_in[ch] = lerp_v(ha4_ff[ch], hb4_ff[ch], fy4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         vb5_ff <= vb5_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 6: divide by 255 through the reciprocal and saturate full white.
   // -------------------------------------------------------------------------
   function automatic out_type div255_sat(input vblend_type v);
      logic [DIVP_W-1:0] prod;
      logic [Q_W-1:0]    q;
      prod = DIVP_W'(v) * DIVP_W'(RECIP_255);
      q    = prod[DIV_SHIFT +: Q_W];
      return q[OUT_W] ? {OUT_W{1'b1}} : q[OUT_W-1:0];
   endfunction

   out_type out6_in [NUM_CH];
   out_type out6_ff [NUM_CH];

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         out6_in[ch] = div255_sat(vb5_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         out6_ff <= out6_in;
      end
   end

   // Hold the response word until the sink takes it.
   assign rsp_if.valid     = v6_ff;
   assign rsp_if.out_red   = out6_ff[CH_RED];
   assign rsp_if.out_green = out6_ff[CH_GREEN];
   assign rsp_if.out_blue  = out6_ff[CH_BLUE];
endmodule

// ===== design/bgu_checker.sv =====
// ----------------------------------------------------------------------------
// bgu_checker: port-level checks for the upscaler
// Stall behavior, config acceptance and reset of the response channel.
// ----------------------------------------------------------------------------
`include "bilinear_grid_upscaler_assert.svh"

module bgu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bgu_pkg::out_type  rsp_red,
   input bgu_pkg::out_type  rsp_green,
   input bgu_pkg::out_type  rsp_blue,
   input logic              csr_valid,
   input logic              csr_ready
);
   import bgu_pkg::*;

   // Config words are never back-pressured.
   `BGU_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

   // With the output free, the pipeline never stalls the request side.
   `BGU_ASSERT_NOW(a_req_ready, clock, reset, (!rsp_valid || rsp_ready), req_ready)

   // Reset empties the pipeline.
   `BGU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A stalled response word holds.
   `BGU_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready), (rsp_valid && $stable({rsp_red, rsp_green, rsp_blue})))
endmodule

bind bilinear_grid_upscaler bgu_checker u_bgu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_red   (rsp_if.out_red),
   .rsp_green (rsp_if.out_green),
   .rsp_blue  (rsp_if.out_blue),
   .csr_valid (csr_if.valid),
   .csr_ready (csr_if.ready)
);
